// ===== hw/rtl/lzssd_pkg.sv =====
// lzssd_pkg: shared types and constants of the split stream lzss decoder
// no dependencies; imported by lzssd_ctrl, lzssd_datapath and the top level
`timescale 1ns / 1ps

package lzssd_pkg;

  // input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_FLAG  = 2'd1;
  localparam logic [1:0] MODE_TOKEN = 2'd2;

  // token fields and frame constants
  localparam int          SIZE_W      = 24;
  localparam int          LEN_W       = 6;
  localparam logic [5:0]  MATCH_BIAS  = 6'd3;
  localparam logic [15:0] START_POS   = 16'h07DE;
  localparam logic [7:0]  FLAG_TOP    = 8'h80;
  localparam int          POS_SHIFT   = 5;

  // what the next emitted result is made from
  typedef enum logic [1:0] {
    EMIT_LIT,
    EMIT_COPY,
    EMIT_ERR
  } emit_kind_t;

  // controller to datapath
  typedef struct packed {
    logic       frame_start;
    logic       flag_load;
    logic       token_load;
    logic       mem_read;
    logic       emit;
    emit_kind_t emit_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic token_bad;
    logic token_match;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// ===== hw/rtl/lzss_split_stream_decoder.sv =====
// lzss_split_stream_decoder: top level of the split stream lzss decoder
// depends on lzssd_pkg, lzssd_ctrl and lzssd_datapath
`timescale 1ns / 1ps

// LZSS decoder with a circular history of DICT_SIZE bytes, fed by one input
// channel that carries start, flag byte and token transactions tagged by mode.
// A literal token, or a token that draws an error result, gives one result.
// A match token produces n bytes: each byte is a read of the single port
// history memory followed by its write-back and the load of the output
// register. A new item is taken only after the last byte of the previous
// token is in the output register; that register lets the next item in while
// its result still waits on the output side. History cleared at frame start
// is tracked by a fill count, so a start costs no clearing pass. The user
// must write the frame size through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
module lzss_split_stream_decoder #(
  parameter int DICT_SIZE   = 2048,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lzssd_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [15:0]                  in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         last_of_run,
  output logic                         frame_done,
  output logic                         token_error
);
  import lzssd_pkg::*;

  cmd_t    cmd;
  status_t status;

  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lzssd_datapath #(
    .DICT_SIZE   (DICT_SIZE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_value    (in_value),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .frame_done  (frame_done),
    .token_error (token_error)
  );

  // a result is never written over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded while output register held a pending result");

  // no input transaction while a token is still producing results
  a_no_take_during_emit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !cmd.emit && !cmd.mem_read)
    else $error("input taken while a token was still in progress");

  // an error result is a lone, zero, unfinished result
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_error) |-> (last_of_run && !frame_done && out_byte == 8'd0))
    else $error("malformed error result");

endmodule

// ===== hw/rtl/lzssd_ctrl.sv =====
// lzssd_ctrl: sequencing state machine of the lzss decoder
// depends on lzssd_pkg; drives the datapath through cmd_t, watches status_t
`timescale 1ns / 1ps

module lzssd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        mode,
  output logic              in_ready,
  input  lzssd_pkg::status_t status,
  output lzssd_pkg::cmd_t   cmd
);
  import lzssd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t     state;
  emit_kind_t kind;

  logic take;

  // items are taken only between tokens
  assign in_ready = (state == S_IDLE);
  assign take     = in_ready && in_valid;

  // command decode
  always_comb begin
    cmd.frame_start = take && (mode == MODE_START);
    cmd.flag_load   = take && (mode == MODE_FLAG);
    cmd.token_load  = take && (mode == MODE_TOKEN) && !status.token_bad;
    cmd.mem_read    = (state == S_READ);
    cmd.emit        = (state == S_EMIT) && status.out_free;
    cmd.emit_kind   = kind;
  end

  // state and result kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= EMIT_LIT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take && (mode == MODE_TOKEN)) begin
            if (status.token_bad) begin
              kind  <= EMIT_ERR;
              state <= S_EMIT;
            end else if (status.token_match) begin
              kind  <= EMIT_COPY;
              state <= S_READ;
            end else begin
              kind  <= EMIT_LIT;
              state <= S_EMIT;
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (status.out_free) begin
            state <= status.emit_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/lzssd_datapath.sv =====
// lzssd_datapath: history memory, flag and count registers, output register
// depends on lzssd_pkg; commanded by lzssd_ctrl
`timescale 1ns / 1ps

module lzssd_datapath #(
  parameter int DICT_SIZE   = 2048,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lzssd_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic [15:0]                  in_value,
  input  lzssd_pkg::cmd_t              cmd,
  output lzssd_pkg::status_t           status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [7:0]                   out_byte,
  output logic                         last_of_run,
  output logic                         frame_done,
  output logic                         token_error
);
  import lzssd_pkg::*;

  localparam int ADDR_W = $clog2(DICT_SIZE);
  localparam int FILL_W = ADDR_W + 1;
  localparam int CMP_W  = (COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W;
  localparam logic [ADDR_W-1:0] START_ADDR = START_POS[ADDR_W-1:0];
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(DICT_SIZE);

  logic [7:0]             history [DICT_SIZE];
  logic [7:0]             rd_data;
  logic                   rd_valid;
  logic [ADDR_W-1:0]      write_pos;
  logic [FILL_W-1:0]      fill;
  logic [7:0]             flag_byte;
  logic [7:0]             flag_mask;
  logic [COUNT_WIDTH-1:0] bytes_emitted;
  logic [SIZE_W-1:0]      frame_size;
  logic [ADDR_W-1:0]      src;
  logic [LEN_W-1:0]       len;
  logic [7:0]             lit;

  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   done_next;
  logic                   is_err;
  logic [7:0]             emit_byte;
  logic [ADDR_W-1:0]      src_offset;

  // token checks against the current flag and count state
  assign status.token_bad   = (flag_mask == 8'd0) ||
                              (CMP_W'(bytes_emitted) >= CMP_W'(frame_size));
  assign status.token_match = |(flag_byte & flag_mask);
  assign status.out_free    = !out_valid || out_ready;

  // next result
  assign is_err    = (cmd.emit_kind == EMIT_ERR);
  assign count_inc = bytes_emitted + 1'b1;
  assign done_next = (CMP_W'(count_inc) == CMP_W'(frame_size));
  assign status.emit_last = is_err || (cmd.emit_kind == EMIT_LIT) ||
                            (len == LEN_W'(1)) || done_next;

  always_comb begin
    case (cmd.emit_kind)
      EMIT_LIT:  emit_byte = lit;
      EMIT_COPY: emit_byte = rd_valid ? rd_data : 8'd0;
      default:   emit_byte = 8'd0;
    endcase
  end

  // distance of the read address from the frame start position
  assign src_offset = src - START_ADDR;

  // history memory: read in the read step, written in the emit step
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_data  <= history[src];
      rd_valid <= ({1'b0, src_offset} < fill);
    end
    if (cmd.emit && !is_err) begin
      history[write_pos] <= emit_byte;
    end
  end

  // token operands
  always_ff @(posedge clk) begin
    if (cmd.token_load) begin
      src <= ADDR_W'(in_value >> POS_SHIFT);
      len <= LEN_W'(in_value[4:0]) + MATCH_BIAS;
      lit <= in_value[7:0];
    end else if (cmd.emit && (cmd.emit_kind == EMIT_COPY)) begin
      src <= src + 1'b1;
      len <= len - 1'b1;
    end
  end

  // frame, flag and count state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos     <= START_ADDR;
      fill          <= '0;
      flag_byte     <= 8'd0;
      flag_mask     <= 8'd0;
      bytes_emitted <= '0;
      frame_size    <= '0;
    end else begin
      if (cfg_we) begin
        frame_size <= cfg_wdata;
      end
      if (cmd.frame_start) begin
        write_pos     <= START_ADDR;
        fill          <= '0;
        flag_byte     <= 8'd0;
        flag_mask     <= 8'd0;
        bytes_emitted <= '0;
      end else if (cmd.flag_load) begin
        flag_byte <= in_value[7:0];
        flag_mask <= FLAG_TOP;
      end else if (cmd.token_load) begin
        flag_mask <= flag_mask >> 1;
      end else if (cmd.emit && !is_err) begin
        write_pos     <= write_pos + 1'b1;
        bytes_emitted <= count_inc;
        if (fill != FILL_FULL) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= emit_byte;
      last_of_run <= status.emit_last;
      frame_done  <= !is_err && done_next;
      token_error <= is_err;
    end
  end

endmodule
